FILE: sv/hrlp_pkg.sv
// Shared types, codes and token tables for the HTTP request line parser.
package hrlp_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int POS_W = $clog2(BUFFER_BYTES + 1);
  localparam int OUT_W = 12;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_INC  = 2'd1;
  localparam status_t ST_ERR  = 2'd2;
  localparam status_t ST_NONE = 2'd3;

  typedef logic [2:0] method_t;
  localparam method_t M_NONE = 3'd0;
  localparam method_t M_GET  = 3'd1;
  localparam method_t M_HEAD = 3'd2;
  localparam method_t M_POST = 3'd3;
  localparam method_t M_PUT  = 3'd4;

  typedef logic [1:0] version_t;
  localparam version_t VER_NONE = 2'd0;
  localparam version_t VER_10   = 2'd1;
  localparam version_t VER_11   = 2'd2;

  // One result as it leaves the parse logic; hit is high when the beat yields one.
  typedef struct packed {
    logic             hit;
    status_t          status;
    method_t          method;
    version_t         version;
    logic [OUT_W-1:0] uri_offset;
    logic [OUT_W-1:0] uri_length;
  } res_t;

  function automatic logic [7:0] tok_get(input logic [2:0] k);
    case (k)
      3'd0:    tok_get = "E";
      3'd1:    tok_get = "T";
      default: tok_get = " ";
    endcase
  endfunction

  function automatic logic [7:0] tok_head(input logic [2:0] k);
    case (k)
      3'd0:    tok_head = "E";
      3'd1:    tok_head = "A";
      3'd2:    tok_head = "D";
      default: tok_head = " ";
    endcase
  endfunction

  function automatic logic [7:0] tok_post(input logic [2:0] k);
    case (k)
      3'd0:    tok_post = "O";
      3'd1:    tok_post = "S";
      3'd2:    tok_post = "T";
      default: tok_post = " ";
    endcase
  endfunction

  function automatic logic [7:0] tok_put(input logic [2:0] k);
    case (k)
      3'd0:    tok_put = "U";
      3'd1:    tok_put = "T";
      default: tok_put = " ";
    endcase
  endfunction

  function automatic logic [7:0] tok_ver(input logic [2:0] k);
    case (k)
      3'd0:    tok_ver = "H";
      3'd1:    tok_ver = "T";
      3'd2:    tok_ver = "T";
      3'd3:    tok_ver = "P";
      3'd4:    tok_ver = "/";
      3'd5:    tok_ver = "1";
      default: tok_ver = ".";
    endcase
  endfunction

endpackage

FILE: sv/hrlp_parse.sv
// Request line state machine: parse state registers and per-byte next-state logic.
module hrlp_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last,
  output hrlp_pkg::res_t     res
);

  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_GET    = 3'd1;
  localparam logic [2:0] PH_HEAD   = 3'd2;
  localparam logic [2:0] PH_P      = 3'd3;
  localparam logic [2:0] PH_URI    = 3'd4;
  localparam logic [2:0] PH_VER    = 3'd5;
  localparam logic [2:0] PH_DIGIT  = 3'd6;
  localparam logic [2:0] PH_ABSORB = 3'd7;

  localparam int PW = hrlp_pkg::POS_W;
  localparam int OW = hrlp_pkg::OUT_W;
  localparam int CW = (PW > OW) ? PW : OW;

  logic [2:0]             phase, phase_next;
  logic [2:0]             tok, tok_next;
  logic [PW-1:0]          pos, pos_next;
  logic [2:0]             method, method_next;
  logic [1:0]             match, match_next;
  logic [PW-1:0]          ustart, ustart_next;
  logic [PW-1:0]          ucount, ucount_next;
  logic                   decided, decided_next;
  hrlp_pkg::status_t      status;
  hrlp_pkg::version_t     version;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic logic [OW-1:0] clip(input logic [PW-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    clip = (ext > CW'(hrlp_pkg::OUT_MAX)) ? hrlp_pkg::OUT_MAX : ext[OW-1:0];
  endfunction

  always_comb begin
    logic [1:0] m;
    m            = match;
    phase_next   = phase;
    tok_next     = tok;
    pos_next     = (pos < PW'(hrlp_pkg::BUFFER_BYTES)) ? pos + 1'b1 : pos;
    method_next  = method;
    ustart_next  = ustart;
    ucount_next  = ucount;
    decided_next = decided;
    status       = hrlp_pkg::ST_NONE;
    version      = hrlp_pkg::VER_NONE;

    unique case (phase)
      PH_FIRST: begin
        tok_next = 3'd0;
        m        = 2'b11;
        if (data_byte == "G") phase_next = PH_GET;
        else if (data_byte == "H") phase_next = PH_HEAD;
        else if (data_byte == "P") phase_next = PH_P;
        else status = hrlp_pkg::ST_ERR;
      end
      PH_GET: begin
        if (tok < 3'd3 && data_byte != hrlp_pkg::tok_get(tok)) m = m & 2'b10;
        tok_next = tok + 1'b1;
        if (tok >= 3'd2) begin
          if (m[0]) begin
            method_next = hrlp_pkg::M_GET;
            ustart_next = pos_next;
            phase_next  = PH_URI;
          end else begin
            status = hrlp_pkg::ST_ERR;
          end
        end
      end
      PH_HEAD: begin
        if (tok < 3'd4 && data_byte != hrlp_pkg::tok_head(tok)) m = m & 2'b10;
        tok_next = tok + 1'b1;
        if (tok >= 3'd3) begin
          if (m[0]) begin
            method_next = hrlp_pkg::M_HEAD;
            ustart_next = pos_next;
            phase_next  = PH_URI;
          end else begin
            status = hrlp_pkg::ST_ERR;
          end
        end
      end
      PH_P: begin
        if (tok < 3'd4 && data_byte != hrlp_pkg::tok_post(tok)) m = m & 2'b10;
        if (tok < 3'd3 && data_byte != hrlp_pkg::tok_put(tok)) m = m & 2'b01;
        tok_next = tok + 1'b1;
        if (tok >= 3'd3) begin
          if (m[0]) begin
            method_next = hrlp_pkg::M_POST;
            ustart_next = pos_next;
            phase_next  = PH_URI;
          end else if (m[1]) begin
            // PUT: the byte that failed the POST test is already the first URI byte.
            method_next = hrlp_pkg::M_PUT;
            ustart_next = pos;
            phase_next  = PH_URI;
            if (is_ws(data_byte)) begin
              ucount_next = '0;
              phase_next  = PH_VER;
              tok_next    = 3'd0;
              m           = 2'b11;
            end
          end else begin
            status = hrlp_pkg::ST_ERR;
          end
        end
      end
      PH_URI: begin
        if (is_ws(data_byte)) begin
          ucount_next = (pos >= ustart) ? pos - ustart : '0;
          phase_next  = PH_VER;
          tok_next    = 3'd0;
          m           = 2'b11;
        end
      end
      PH_VER: begin
        if (tok < 3'd7 && data_byte != hrlp_pkg::tok_ver(tok)) m = m & 2'b10;
        tok_next = tok + 1'b1;
        if (tok >= 3'd6) begin
          if (m[0]) phase_next = PH_DIGIT;
          else status = hrlp_pkg::ST_ERR;
        end
      end
      PH_DIGIT: begin
        if (data_byte == "0") begin
          status  = hrlp_pkg::ST_OK;
          version = hrlp_pkg::VER_10;
        end else if (data_byte == "1") begin
          status  = hrlp_pkg::ST_OK;
          version = hrlp_pkg::VER_11;
        end else begin
          status = hrlp_pkg::ST_ERR;
        end
      end
      PH_ABSORB: begin
      end
      default: begin
      end
    endcase

    if (status != hrlp_pkg::ST_NONE) begin
      phase_next   = PH_ABSORB;
      decided_next = 1'b1;
    end
    if (last && status == hrlp_pkg::ST_NONE && !decided) status = hrlp_pkg::ST_INC;

    res.hit        = (status != hrlp_pkg::ST_NONE);
    res.status     = status;
    res.method     = method_next;
    res.version    = version;
    res.uri_offset = clip(ustart_next);
    res.uri_length = clip(ucount_next);

    match_next = m;
    // The last byte of a buffer rearms the parser.
    if (last) begin
      phase_next   = PH_FIRST;
      tok_next     = 3'd0;
      pos_next     = '0;
      method_next  = hrlp_pkg::M_NONE;
      match_next   = 2'b11;
      ustart_next  = '0;
      ucount_next  = '0;
      decided_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_FIRST;
      tok     <= 3'd0;
      pos     <= '0;
      method  <= hrlp_pkg::M_NONE;
      match   <= 2'b11;
      ustart  <= '0;
      ucount  <= '0;
      decided <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      tok     <= tok_next;
      pos     <= pos_next;
      method  <= method_next;
      match   <= match_next;
      ustart  <= ustart_next;
      ucount  <= ucount_next;
      decided <= decided_next;
    end
  end

endmodule

FILE: sv/http_request_line_parser.sv
// Top level of the HTTP request line parser: input register, parse logic, result register.
// A deciding byte waits in the input register, and its result is loaded into the result register.
// Throughput: one byte per cycle; the parse state advances by one byte per cycle, except in a stall.
// A full result register stalls the input register only when a new result is due.
// Reset (rst, synchronous, active high) empties both registers and rearms the parser.
module http_request_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [1:0] parse_status, [4:2] method_code,
                                 // [6:5] version_code, [18:7] uri_offset,
                                 // [30:19] uri_length, [31] zero
);

  // Input register: one byte beat held until the parse logic takes it.
  logic           in_valid;
  logic [7:0]     in_byte;
  logic           in_last;

  // The parse state advances by one byte whenever the held byte can leave.
  // A byte that produces no result never waits for the output side; a byte
  // that produces one leaves when the result register is free or being
  // drained in this cycle.
  logic           advance;
  hrlp_pkg::res_t res;

  // Result register.
  hrlp_pkg::res_t out_res;

  assign advance  = in_valid && (!m_tvalid || m_tready || !res.hit);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  hrlp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last      (in_last),
    .res       (res)
  );

  // A new result is loaded only when the register is empty or drains now,
  // which advance already guarantees for beats that carry a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res.hit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.uri_length, out_res.uri_offset, out_res.version,
                    out_res.method, out_res.status};

  // A held result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (advance && res.hit) |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while full");

  // Offered results never carry the internal no-result code.
  a_status_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != hrlp_pkg::ST_NONE))
    else $error("result beat with no-result status");

  // A version is reported only together with an ok status.
  a_version_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[6:5] != hrlp_pkg::VER_NONE) |-> (m_tdata[1:0] == hrlp_pkg::ST_OK))
    else $error("version reported without ok status");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the HTTP request line parser: byte beats in, one result beat per buffer.
module tb_top;

  // The random part stops once this many bytes of request buffers have been sent.
  localparam int ITEM_GOAL = 1950;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 8;

  // Fixed tokens that follow the first byte of each method, and the version prefix.
  // The first character of each string sits in the most significant byte.
  localparam logic [23:0] GET_TEXT  = "ET ";
  localparam logic [31:0] HEAD_TEXT = "EAD ";
  localparam logic [31:0] POST_TEXT = "OST ";
  localparam logic [23:0] PUT_TEXT  = "UT ";
  localparam logic [55:0] VER_TEXT  = "HTTP/1.";

  typedef enum logic [3:0] {
    PH_FIRST, PH_GET, PH_HEAD, PH_P, PH_URI, PH_VER, PH_DIGIT, PH_ABSORB
  } phase_e;

  typedef struct packed {
    hrlp_pkg::status_t          status;
    hrlp_pkg::method_t          method;
    hrlp_pkg::version_t         version;
    logic [hrlp_pkg::OUT_W-1:0] uri_offset;
    logic [hrlp_pkg::OUT_W-1:0] uri_length;
  } line_result_t;

  // One directed beat. When typed_in is set, the expected result is the one in the row;
  // otherwise the result, if any, comes from the line predictor.
  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic         typed_in;
    line_result_t want;
  } step_row_t;

  localparam line_result_t NO_R  = '0;
  localparam line_result_t ERR_R = '{hrlp_pkg::ST_ERR, hrlp_pkg::M_NONE, hrlp_pkg::VER_NONE,
                                     12'd0, 12'd0};
  localparam line_result_t INC_R = '{hrlp_pkg::ST_INC, hrlp_pkg::M_NONE, hrlp_pkg::VER_NONE,
                                     12'd0, 12'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  int cycles = 0;
  int mismatches = 0;
  wire calm = (cycles >= 800) && (cycles < 1400);

  line_result_t expected_lines[$];
  logic [7:0]   frame_q[$];

  // Predictor state of the request line parser.
  phase_e                     ph;
  logic [2:0]                 tok_idx;
  logic [hrlp_pkg::POS_W-1:0] pos_cnt;
  logic [hrlp_pkg::POS_W-1:0] uri_base;
  logic [hrlp_pkg::POS_W-1:0] uri_len;
  hrlp_pkg::method_t          method_seen;
  logic [1:0]                 still_match;  // bit 0: main token, bit 1: PUT
  logic                       decided;

  // Directed beats: extremes of the byte, a bad first byte, a method cut short by the
  // buffer end, PUT with an empty URI decided on the last byte, a POST/PUT mismatch that
  // is only an error once the fourth byte has come, and a HEAD cut short.
  step_row_t plan [25] = '{
    '{8'h00, 1'b1, 1'b1, ERR_R},
    '{8'hFF, 1'b1, 1'b1, ERR_R},
    '{"G",   1'b0, 1'b0, NO_R},
    '{"X",   1'b1, 1'b1, INC_R},
    '{"P",   1'b0, 1'b0, NO_R},
    '{"U",   1'b0, 1'b0, NO_R},
    '{"T",   1'b0, 1'b0, NO_R},
    '{8'h20, 1'b0, 1'b0, NO_R},
    '{8'h20, 1'b0, 1'b0, NO_R},
    '{"H",   1'b0, 1'b0, NO_R},
    '{"T",   1'b0, 1'b0, NO_R},
    '{"T",   1'b0, 1'b0, NO_R},
    '{"P",   1'b0, 1'b0, NO_R},
    '{"/",   1'b0, 1'b0, NO_R},
    '{"1",   1'b0, 1'b0, NO_R},
    '{".",   1'b0, 1'b0, NO_R},
    '{"1",   1'b1, 1'b0, NO_R},
    '{"P",   1'b0, 1'b0, NO_R},
    '{"O",   1'b0, 1'b0, NO_R},
    '{"S",   1'b0, 1'b0, NO_R},
    '{"T",   1'b0, 1'b0, NO_R},
    '{"X",   1'b1, 1'b1, ERR_R},
    '{"H",   1'b0, 1'b0, NO_R},
    '{"E",   1'b0, 1'b0, NO_R},
    '{"A",   1'b1, 1'b1, INC_R}
  };

  http_request_line_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // Byte k of an n-character token held in the low bytes of text.
  function automatic logic [7:0] text_char(input logic [55:0] text, input int n, input int k);
    return text[8*(n-1-k) +: 8];
  endfunction

  function automatic logic [hrlp_pkg::OUT_W-1:0] clip_out(
      input logic [hrlp_pkg::POS_W-1:0] v);
    return (v > hrlp_pkg::OUT_MAX) ? hrlp_pkg::OUT_MAX : v[hrlp_pkg::OUT_W-1:0];
  endfunction

  function automatic void rearm();
    ph = PH_FIRST;
    tok_idx = '0;
    pos_cnt = '0;
    uri_base = '0;
    uri_len = '0;
    method_seen = hrlp_pkg::M_NONE;
    still_match = 2'b11;
    decided = 1'b0;
  endfunction

  // A whitespace byte ends the URI and opens the version token.
  function automatic void uri_scan(input logic [7:0] b, input logic [hrlp_pkg::POS_W-1:0] p);
    if (is_space(b)) begin
      uri_len = (p >= uri_base) ? p - uri_base : '0;
      ph = PH_VER;
      tok_idx = '0;
      still_match = 2'b11;
    end
  endfunction

  // Advances the predicted parser by one byte; returns 1 when the byte yields a result.
  function automatic logic parse_byte(input logic [7:0] b, input logic l,
                                      output line_result_t r);
    logic [hrlp_pkg::POS_W-1:0] p;
    logic [hrlp_pkg::POS_W-1:0] nx;
    hrlp_pkg::status_t          st;
    hrlp_pkg::version_t         ver;
    logic [2:0]                 k;
    p = pos_cnt;
    nx = (pos_cnt < hrlp_pkg::BUFFER_BYTES) ? pos_cnt + 1'b1 : pos_cnt;
    st = hrlp_pkg::ST_NONE;
    ver = hrlp_pkg::VER_NONE;
    k = tok_idx;
    pos_cnt = nx;
    case (ph)
      PH_FIRST: begin
        tok_idx = '0;
        still_match = 2'b11;
        if (b == "G") ph = PH_GET;
        else if (b == "H") ph = PH_HEAD;
        else if (b == "P") ph = PH_P;
        else st = hrlp_pkg::ST_ERR;
      end
      PH_GET: begin
        if (k < 3 && b != text_char(56'(GET_TEXT), 3, int'(k))) still_match[0] = 1'b0;
        tok_idx = k + 1'b1;
        if (k >= 2) begin
          if (still_match[0]) begin
            method_seen = hrlp_pkg::M_GET;
            uri_base = nx;
            ph = PH_URI;
          end else begin
            st = hrlp_pkg::ST_ERR;
          end
        end
      end
      PH_HEAD: begin
        if (k < 4 && b != text_char(56'(HEAD_TEXT), 4, int'(k))) still_match[0] = 1'b0;
        tok_idx = k + 1'b1;
        if (k >= 3) begin
          if (still_match[0]) begin
            method_seen = hrlp_pkg::M_HEAD;
            uri_base = nx;
            ph = PH_URI;
          end else begin
            st = hrlp_pkg::ST_ERR;
          end
        end
      end
      PH_P: begin
        // Both candidates are tracked; POST wins when its four bytes match, and
        // otherwise, if PUT still matches, the fourth byte already belongs to the URI of a PUT.
        if (k < 4 && b != text_char(56'(POST_TEXT), 4, int'(k))) still_match[0] = 1'b0;
        if (k < 3 && b != text_char(56'(PUT_TEXT), 3, int'(k))) still_match[1] = 1'b0;
        tok_idx = k + 1'b1;
        if (k >= 3) begin
          if (still_match[0]) begin
            method_seen = hrlp_pkg::M_POST;
            uri_base = nx;
            ph = PH_URI;
          end else if (still_match[1]) begin
            method_seen = hrlp_pkg::M_PUT;
            uri_base = p;
            ph = PH_URI;
            uri_scan(b, p);
          end else begin
            st = hrlp_pkg::ST_ERR;
          end
        end
      end
      PH_URI: begin
        uri_scan(b, p);
      end
      PH_VER: begin
        if (k < 7 && b != text_char(VER_TEXT, 7, int'(k))) still_match[0] = 1'b0;
        tok_idx = k + 1'b1;
        if (k >= 6) begin
          if (still_match[0]) ph = PH_DIGIT;
          else st = hrlp_pkg::ST_ERR;
        end
      end
      PH_DIGIT: begin
        if (b == "0") begin
          st = hrlp_pkg::ST_OK;
          ver = hrlp_pkg::VER_10;
        end else if (b == "1") begin
          st = hrlp_pkg::ST_OK;
          ver = hrlp_pkg::VER_11;
        end else begin
          st = hrlp_pkg::ST_ERR;
        end
      end
      default: begin
      end
    endcase
    if (st != hrlp_pkg::ST_NONE) begin
      ph = PH_ABSORB;
      decided = 1'b1;
    end
    if (l && st == hrlp_pkg::ST_NONE && !decided) st = hrlp_pkg::ST_INC;
    r = '{st, method_seen, ver, clip_out(uri_base), clip_out(uri_len)};
    if (l) rearm();
    return st != hrlp_pkg::ST_NONE;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch in %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycles);
    mismatches++;
  endtask

  // Compares one accepted result beat with the oldest expectation.
  task automatic check_beat(input logic [31:0] beat);
    line_result_t got;
    line_result_t want;
    got = '{beat[1:0], beat[4:2], beat[6:5], beat[18:7], beat[30:19]};
    if (expected_lines.size() == 0) begin
      report_mismatch("result beat with nothing pending", 0, beat);
    end else begin
      want = expected_lines.pop_front();
      if (got.status != want.status) report_mismatch("parse_status", want.status, got.status);
      if (got.method != want.method) report_mismatch("method_code", want.method, got.method);
      if (got.version != want.version) begin
        report_mismatch("version_code", want.version, got.version);
      end
      if (got.uri_offset != want.uri_offset) begin
        report_mismatch("uri_offset", want.uri_offset, got.uri_offset);
      end
      if (got.uri_length != want.uri_length) begin
        report_mismatch("uri_length", want.uri_length, got.uri_length);
      end
    end
  endtask

  // Result side: m_tready is low about ten percent of the time outside the calm window.
  // The beat is sampled at the edge, before the new m_tready takes effect.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 10);
    if (!rst && m_tvalid && m_tready) check_beat(m_tdata);
  end

  // Offers one byte beat, with an occasional gap in front, and returns at the edge
  // where it is accepted. The valid stays high when the next beat follows at once.
  task automatic drive_byte(input logic [7:0] b, input logic l);
    while (!calm && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic l);
    line_result_t r;
    drive_byte(b, l);
    if (parse_byte(b, l, r)) expected_lines.push_back(r);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  // Builds one request buffer. Most are well-formed request lines with random URIs
  // and separators; some get one byte overwritten, some are cut short, and a few are
  // pure noise.
  task automatic build_frame();
    int         shape;
    int         ulen;
    int         spot;
    int         cut;
    logic [7:0] c;
    frame_q.delete();
    shape = $urandom_range(99);
    if (shape < 10) begin
      repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(3))
        0: push_text("GET ");
        1: push_text("HEAD ");
        2: push_text("POST ");
        default: push_text("PUT ");
      endcase
      ulen = $urandom_range(0, 8);
      repeat (ulen) begin
        do c = 8'($urandom_range(255)); while (is_space(c));
        frame_q.push_back(c);
      end
      c = ($urandom_range(5) == 0) ? 8'h20 : 8'h09 + 8'($urandom_range(4));
      frame_q.push_back(c);
      push_text("HTTP/1.");
      c = ($urandom_range(99) < 85) ? 8'("0" + $urandom_range(1)) : 8'($urandom_range(255));
      frame_q.push_back(c);
      repeat ($urandom_range(3)) frame_q.push_back(8'($urandom_range(255)));
      if (shape < 30) begin
        // Overwrite one byte, half the time among the first seven bytes.
        spot = $urandom_range(1) ? $urandom_range(frame_q.size() - 1) : $urandom_range(6);
        frame_q[spot] = 8'($urandom_range(255));
      end else if (shape < 45) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        frame_q = frame_q[0:cut-1];
      end
    end
  endtask

  initial begin
    line_result_t r;
    logic         hit;
    int           random_items;

    rearm();
    random_items = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      drive_byte(plan[i].data, plan[i].last);
      hit = parse_byte(plan[i].data, plan[i].last, r);
      if (plan[i].typed_in) expected_lines.push_back(plan[i].want);
      else if (hit) expected_lines.push_back(r);
    end

    while (random_items < ITEM_GOAL) begin
      build_frame();
      random_items += frame_q.size();
      foreach (frame_q[i]) feed_byte(frame_q[i], i == frame_q.size() - 1);
    end
    s_tvalid <= 1'b0;

    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
